// ===== hw/rtl/stsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsm_pkg
// Shared types and constants of the sparse template score map core.
// ----------------------------------------------------------------------------
package stsm_pkg;

	localparam int MAX_MAPS      = 16;
	localparam int MAX_ROWS      = 64;
	localparam int MAX_COLS      = 64;
	localparam int MAX_TEMPLATES = 4;
	localparam int MAX_ELEMENTS  = 64;

	localparam int MAP_AW    = 16;
	localparam int MAP_W     = 16;
	localparam int ELEM_AW   = 8;
	localparam int ELEM_W    = 40;
	localparam int ACC_W     = 38;
	localparam int RND_W     = ACC_W - 12;
	localparam int DIV_STEPS = 7;

	typedef enum logic [1:0] {
		REQ_MAP   = 2'd0,
		REQ_ELEM  = 2'd1,
		REQ_QUERY = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		PS_COMPUTED = 2'd0,
		PS_MARGIN   = 2'd1,
		PS_OUTSIDE  = 2'd2,
		PS_BADMAP   = 2'd3
	} pstat_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_MARG,
		S_CHECK,
		S_RUN,
		S_DRAIN,
		S_RND,
		S_EMIT
	} state_t;

	localparam logic [2:0] REG_MAP_ROWS  = 3'd0;
	localparam logic [2:0] REG_MAP_COLS  = 3'd1;
	localparam logic [2:0] REG_SUBSAMPLE = 3'd2;
	localparam logic [2:0] REG_TPP       = 3'd3;
	localparam logic [2:0] REG_LOG_NORM  = 3'd4;
	localparam logic [2:0] REG_MARGIN    = 3'd5;

	typedef struct packed {
		logic [6:0]         map_rows;
		logic [6:0]         map_cols;
		logic [6:0]         subsample;
		logic [4:0]         tpp;
		logic signed [31:0] log_norm;
		logic [15:0]        margin_ratio;
	} cfg_t;

	typedef struct packed {
		logic       map_wr;
		logic       elem_wr;
		logic       q_load;
		logic       div_step;
		logic       marg_load;
		logic       issue;
		logic [5:0] elem_idx;
		logic       rnd;
		logic       emit;
		pstat_t     emit_status;
	} cmd_t;

	typedef struct packed {
		logic       outside;
		logic       margin;
		logic       pipe_empty;
		logic       bad;
		logic [6:0] elem_count;
	} sts_t;

endpackage

// ===== hw/rtl/stsm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsm_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module stsm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/stsm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsm_ctrl
// Request sequencer: accepts requests, steps the divider, walks the elements.
// ----------------------------------------------------------------------------
module stsm_ctrl import stsm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] req_type,
	input  sts_t       sts,
	output logic       busy,
	output cmd_t       cmd
);

	state_t     state_q, state_d;
	logic [2:0] cnt_q;
	logic [6:0] idx_q;
	logic       accept;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && req_type == REQ_QUERY) state_d = S_DIV;
			end
			S_DIV: begin
				if (cnt_q == 3'(DIV_STEPS - 1)) state_d = S_MARG;
			end
			S_MARG: state_d = S_CHECK;
			S_CHECK: begin
				if (sts.outside || sts.margin) state_d = S_IDLE;
				else if (sts.elem_count == 7'd0) state_d = S_DRAIN;
				else state_d = S_RUN;
			end
			S_RUN: begin
				if (idx_q + 7'd1 >= sts.elem_count) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (sts.pipe_empty) state_d = S_RND;
			end
			S_RND:  state_d = S_EMIT;
			S_EMIT: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.emit_status = PS_COMPUTED;
		unique case (state_q)
			S_IDLE: begin
				cmd.map_wr  = accept && (req_type == REQ_MAP);
				cmd.elem_wr = accept && (req_type == REQ_ELEM);
				cmd.q_load  = accept && (req_type == REQ_QUERY);
			end
			S_DIV:  cmd.div_step  = 1'b1;
			S_MARG: cmd.marg_load = 1'b1;
			S_CHECK: begin
				if (sts.outside) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = PS_OUTSIDE;
				end else if (sts.margin) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = PS_MARGIN;
				end
			end
			S_RUN: begin
				cmd.issue    = 1'b1;
				cmd.elem_idx = idx_q[5:0];
			end
			S_DRAIN: ;
			S_RND: cmd.rnd = 1'b1;
			S_EMIT: begin
				cmd.emit        = 1'b1;
				cmd.emit_status = sts.bad ? PS_BADMAP : PS_COMPUTED;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_q == S_DIV) ? cnt_q + 3'd1 : 3'd0;
			idx_q   <= (state_q == S_RUN) ? idx_q + 7'd1 : 7'd0;
		end
	end

endmodule

// ===== hw/rtl/stsm_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsm_dp
// Datapath: map and element stores, output size divider, element pipeline,
// accumulator, rounding and saturation.
// ----------------------------------------------------------------------------
module stsm_dp import stsm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	input  cfg_t               cfg,
	input  logic [3:0]         map_index,
	input  logic [5:0]         row,
	input  logic [5:0]         col,
	input  logic signed [15:0] map_value,
	input  logic [1:0]         template_index,
	input  logic [5:0]         element_index,
	input  logic signed [7:0]  row_offset,
	input  logic signed [7:0]  col_offset,
	input  logic [3:0]         part_id,
	input  logic [3:0]         transform_id,
	input  logic signed [15:0] weight,
	output sts_t               sts,
	output logic               done,
	output logic signed [31:0] score,
	output logic [1:0]         position_status
);

	logic [6:0] rows_eff, cols_eff;
	assign rows_eff = (cfg.map_rows > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : cfg.map_rows;
	assign cols_eff = (cfg.map_cols > 7'(MAX_COLS)) ? 7'(MAX_COLS) : cfg.map_cols;

	// stores
	logic                 map_we;
	logic [MAP_AW-1:0]    map_raddr;
	logic [MAP_W-1:0]     map_rdata;
	logic [ELEM_W-1:0]    elem_rdata;
	logic signed [15:0]   min_q [MAX_MAPS];
	logic [6:0]           count_q [MAX_TEMPLATES];
	logic [1:0]           q_tmpl_q;

	assign map_we = cmd.map_wr && ({1'b0, row} < rows_eff) && ({1'b0, col} < cols_eff);

	stsm_ram #(.WIDTH(MAP_W), .DEPTH(1 << MAP_AW)) u_map_ram (
		.clk   (clk),
		.we    (map_we),
		.waddr ({map_index, row, col}),
		.wdata (map_value),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	stsm_ram #(.WIDTH(ELEM_W), .DEPTH(1 << ELEM_AW)) u_elem_ram (
		.clk   (clk),
		.we    (cmd.elem_wr),
		.waddr ({template_index, element_index}),
		.wdata ({row_offset, col_offset, part_id, transform_id, weight}),
		.raddr ({q_tmpl_q, cmd.elem_idx}),
		.rdata (elem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_MAPS; i++) min_q[i] <= 16'sh7FFF;
			for (int i = 0; i < MAX_TEMPLATES; i++) count_q[i] <= '0;
		end else begin
			if (map_we && map_value < min_q[map_index]) min_q[map_index] <= map_value;
			if (cmd.elem_wr) count_q[template_index] <= {1'b0, element_index} + 7'd1;
		end
	end

	// request and output size
	logic [5:0]  q_row_q, q_col_q;
	logic [6:0]  sub_q;
	logic [6:0]  rem_r_q, rem_c_q, quo_r_q, quo_c_q;
	logic [7:0]  rsh_r, rsh_c;
	logic [6:0]  dh_q, dw_q;
	logic [12:0] rsub_q, csub_q;
	logic [22:0] mh, mw;

	assign rsh_r = {rem_r_q, quo_r_q[6]};
	assign rsh_c = {rem_c_q, quo_c_q[6]};
	assign mh    = cfg.margin_ratio * quo_r_q;
	assign mw    = cfg.margin_ratio * quo_c_q;

	always_ff @(posedge clk) begin
		if (cmd.q_load) begin
			q_row_q  <= row;
			q_col_q  <= col;
			q_tmpl_q <= template_index;
			sub_q    <= (cfg.subsample == 7'd0) ? 7'd1 : cfg.subsample;
			rem_r_q  <= '0;
			rem_c_q  <= '0;
			quo_r_q  <= rows_eff;
			quo_c_q  <= cols_eff;
		end
		if (cmd.div_step) begin
			if (rsh_r >= {1'b0, sub_q}) begin
				rem_r_q <= 7'(rsh_r - {1'b0, sub_q});
				quo_r_q <= {quo_r_q[5:0], 1'b1};
			end else begin
				rem_r_q <= rsh_r[6:0];
				quo_r_q <= {quo_r_q[5:0], 1'b0};
			end
			if (rsh_c >= {1'b0, sub_q}) begin
				rem_c_q <= 7'(rsh_c - {1'b0, sub_q});
				quo_c_q <= {quo_c_q[5:0], 1'b1};
			end else begin
				rem_c_q <= rsh_c[6:0];
				quo_c_q <= {quo_c_q[5:0], 1'b0};
			end
		end
		if (cmd.marg_load) begin
			dh_q   <= mh[22:16];
			dw_q   <= mw[22:16];
			rsub_q <= q_row_q * sub_q;
			csub_q <= q_col_q * sub_q;
		end
	end

	assign sts.outside = ({1'b0, q_row_q} >= quo_r_q) || ({1'b0, q_col_q} >= quo_c_q);
	assign sts.margin  = ({1'b0, q_row_q} < dh_q) || ({1'b0, q_row_q} >= quo_r_q - dh_q) ||
	                     ({1'b0, q_col_q} < dw_q) || ({1'b0, q_col_q} >= quo_c_q - dw_q);
	assign sts.elem_count = count_q[q_tmpl_q];

	// element pipeline
	logic               valid_s1, valid_s2, valid_s3;
	logic signed [7:0]  e_roff, e_coff;
	logic [3:0]         e_part, e_trans;
	logic signed [15:0] e_wt;
	logic [8:0]         mi;
	logic signed [14:0] mr, mc;
	logic               in_map;
	logic               oob_s2, bad_s2;
	logic [3:0]         mi_s2;
	logic signed [15:0] wt_s2, v_s3;
	logic signed [31:0] prod_s3;
	logic signed [ACC_W-1:0] acc_q;
	logic               bad_q;

	assign {e_roff, e_coff, e_part, e_trans, e_wt} = elem_rdata;
	assign mi = {5'd0, e_trans} + ({4'd0, cfg.tpp} * {5'd0, e_part});
	assign mr = $signed({2'b0, rsub_q}) + 15'(e_roff);
	assign mc = $signed({2'b0, csub_q}) + 15'(e_coff);
	assign in_map = !mr[14] && !mc[14] && (mr < $signed({8'd0, rows_eff})) &&
	                (mc < $signed({8'd0, cols_eff}));
	assign map_raddr = {mi[3:0], mr[5:0], mc[5:0]};
	assign v_s3 = oob_s2 ? min_q[mi_s2] : $signed(map_rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			bad_q    <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			if (cmd.q_load) bad_q <= 1'b0;
			else if (valid_s2 && bad_s2) bad_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		oob_s2  <= !in_map;
		bad_s2  <= (mi[8:4] != 5'd0);
		mi_s2   <= mi[3:0];
		wt_s2   <= e_wt;
		prod_s3 <= v_s3 * wt_s2;
		if (cmd.q_load) acc_q <= '0;
		else if (valid_s3) acc_q <= acc_q + ACC_W'(prod_s3);
	end

	assign sts.pipe_empty = !(valid_s1 || valid_s2 || valid_s3);
	assign sts.bad        = bad_q;

	// round, subtract, saturate
	logic signed [ACC_W-1:0] acc_b;
	logic signed [RND_W-1:0] rnd_q;
	logic signed [33:0]      diff;
	logic signed [31:0]      sat;
	logic                    done_q;

	assign acc_b = acc_q + ACC_W'(2048);
	assign diff  = 34'(rnd_q) - 34'(cfg.log_norm);
	always_comb begin
		if (diff > 34'sh0_7FFF_FFFF) sat = 32'sh7FFF_FFFF;
		else if (diff < -34'sh0_8000_0000) sat = 32'sh8000_0000;
		else sat = diff[31:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.rnd) rnd_q <= acc_b[ACC_W-1:12];
		if (cmd.emit) begin
			score           <= (cmd.emit_status == PS_COMPUTED) ? sat : 32'sd0;
			position_status <= cmd.emit_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= cmd.emit;
	end

	assign done = done_q;

endmodule

// ===== hw/rtl/sparse_template_score_map_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_template_score_map_core
// Sparse weighted template matching over stored feature maps.
// ----------------------------------------------------------------------------
// Channel   Handshake                  Payload
// request   start / busy               req_type .. weight
// result    done (one-cycle strobe)    score, position_status
// config    psel/penable/pwrite/pready paddr, pwdata, prdata
//
// Map and element writes are taken in idle and do not raise busy. A query holds
// busy through the divider steps, the margin check, the element walk, the
// pipeline drain, rounding and emit; the element walk makes one element read and
// one multiply-accumulate per cycle, and the result strobes as busy falls.
// Queries in the margin or outside the output map end after the check, skip the
// element walk and strobe as busy falls.
// Reset clears map minima to the most positive value and element counts.
// The result cannot be stalled.
// ----------------------------------------------------------------------------
module sparse_template_score_map_core import stsm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         req_type,
	input  logic [3:0]         map_index,
	input  logic [5:0]         row,
	input  logic [5:0]         col,
	input  logic signed [15:0] map_value,
	input  logic [1:0]         template_index,
	input  logic [5:0]         element_index,
	input  logic signed [7:0]  row_offset,
	input  logic signed [7:0]  col_offset,
	input  logic [3:0]         part_id,
	input  logic [3:0]         transform_id,
	input  logic signed [15:0] weight,
	output logic               done,
	output logic signed [31:0] score,
	output logic [1:0]         position_status,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.map_rows     <= 7'd64;
			cfg_q.map_cols     <= 7'd64;
			cfg_q.subsample    <= 7'd1;
			cfg_q.tpp          <= 5'd1;
			cfg_q.log_norm     <= '0;
			cfg_q.margin_ratio <= '0;
		end else if (wr_en) begin
			unique case (paddr[4:2])
				REG_MAP_ROWS:  cfg_q.map_rows     <= pwdata[6:0];
				REG_MAP_COLS:  cfg_q.map_cols     <= pwdata[6:0];
				REG_SUBSAMPLE: cfg_q.subsample    <= pwdata[6:0];
				REG_TPP:       cfg_q.tpp          <= pwdata[4:0];
				REG_LOG_NORM:  cfg_q.log_norm     <= pwdata;
				REG_MARGIN:    cfg_q.margin_ratio <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_MAP_ROWS:  prdata = {25'd0, cfg_q.map_rows};
			REG_MAP_COLS:  prdata = {25'd0, cfg_q.map_cols};
			REG_SUBSAMPLE: prdata = {25'd0, cfg_q.subsample};
			REG_TPP:       prdata = {27'd0, cfg_q.tpp};
			REG_LOG_NORM:  prdata = cfg_q.log_norm;
			REG_MARGIN:    prdata = {16'd0, cfg_q.margin_ratio};
			default:       prdata = '0;
		endcase
	end

	stsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.sts      (sts),
		.busy     (busy),
		.cmd      (cmd)
	);

	stsm_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg             (cfg_q),
		.map_index       (map_index),
		.row             (row),
		.col             (col),
		.map_value       (map_value),
		.template_index  (template_index),
		.element_index   (element_index),
		.row_offset      (row_offset),
		.col_offset      (col_offset),
		.part_id         (part_id),
		.transform_id    (transform_id),
		.weight          (weight),
		.sts             (sts),
		.done            (done),
		.score           (score),
		.position_status (position_status)
	);

endmodule
